### rtl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

  // Width of the decoded length and of the size limit register
  localparam int LEN_W = 24;
  // Lengths must fit in this many bits to be accepted
  localparam int LEN_COUNT_BITS = 24;
  // Control frames carry at most this many payload bytes
  localparam logic [LEN_W-1:0] CTRL_MAX_LEN = LEN_W'(125);
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(1024 * 1024);

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header sizes in bytes, without the mask key
  localparam logic [3:0] HDR_SIZE_SHORT = 4'd2;
  localparam logic [3:0] HDR_SIZE_EXT16 = 4'd4;
  localparam logic [3:0] HDR_SIZE_EXT64 = 4'd10;

  // Extended length bytes minus one, and index of the last mask key byte
  localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
  localparam logic [2:0] EXT64_FIRST_IDX = 3'd7;
  localparam logic [2:0] MASK_LAST_IDX = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_FRAMING  = 2'd0,
    ERR_LEN_TOP  = 2'd1,
    ERR_LIMIT    = 2'd2
  } err_t;

  typedef struct packed {
    kind_t             result_kind;
    logic              final_fragment;
    logic [3:0]        frame_opcode;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W:0]    frame_bytes;
    logic [7:0]        payload_byte;
    logic              last_of_frame;
    err_t              error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/wsdf_parser.sv
// Frame header parser, length checker and payload unmasker.
`timescale 1ns / 1ps
`default_nettype none

module wsdf_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wsdf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  wire logic                        byte_take,
  input  wire logic [7:0]                  stream_byte,
  output logic                             res_valid,
  output wsdf_pkg::result_t                res
);

  localparam int LW = wsdf_pkg::LEN_W;

  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       opcode_r, opcode_nxt;
  logic [LW-1:0]    acc_r, acc_nxt;
  logic             acc_high_r, acc_high_nxt;  // length bits above LW seen
  logic [3:0]       hdr_size_r, hdr_size_nxt;
  logic [2:0]       byte_cnt_r, byte_cnt_nxt;
  logic [31:0]      mask_key_r, mask_key_nxt;
  logic [LW-1:0]    remain_r, remain_nxt;
  logic [1:0]       mask_pos_r, mask_pos_nxt;
  logic [LW-1:0]    max_len_r;

  logic [LW-1:0]    ext_acc;
  logic             ext_high;
  logic [LW-1:0]    remain_dec;
  logic [7:0]       key_byte;

  function automatic logic len_reject(
    input logic [LW-1:0] len,
    input logic          high,
    input logic          fin,
    input logic [3:0]    opc,
    input logic [LW-1:0] max_len
  );
    logic ctrl_bad;
    logic fit_bad;
    ctrl_bad = opc[3] && (!fin || high || (len > wsdf_pkg::CTRL_MAX_LEN));
    fit_bad  = ({{(64-LW){1'b0}}, len} >> wsdf_pkg::LEN_COUNT_BITS) != 64'd0;
    return ctrl_bad || high || (len > max_len) || fit_bad;
  endfunction

  assign ext_acc    = {acc_r[LW-9:0], stream_byte};
  assign ext_high   = acc_high_r || (acc_r[LW-1:LW-8] != 8'd0);
  assign remain_dec = remain_r - LW'(1);

  always_comb begin
    case (mask_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    acc_nxt      = acc_r;
    acc_high_nxt = acc_high_r;
    hdr_size_nxt = hdr_size_r;
    byte_cnt_nxt = byte_cnt_r;
    mask_key_nxt = mask_key_r;
    remain_nxt   = remain_r;
    mask_pos_nxt = mask_pos_r;
    res_valid    = 1'b0;
    res          = '0;

    case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        if (!stream_byte[7]) begin
          res_valid        = 1'b1;
          res.result_kind  = wsdf_pkg::KIND_ERROR;
          res.error_code   = wsdf_pkg::ERR_FRAMING;
          phase_nxt        = wsdf_pkg::PH_HDR0;
        end else if (stream_byte[6:0] == wsdf_pkg::LEN7_EXT16) begin
          acc_nxt      = '0;
          acc_high_nxt = 1'b0;
          hdr_size_nxt = wsdf_pkg::HDR_SIZE_EXT16;
          byte_cnt_nxt = wsdf_pkg::EXT16_LAST_IDX;
          phase_nxt    = wsdf_pkg::PH_EXT;
        end else if (stream_byte[6:0] == wsdf_pkg::LEN7_EXT64) begin
          acc_nxt      = '0;
          acc_high_nxt = 1'b0;
          hdr_size_nxt = wsdf_pkg::HDR_SIZE_EXT64;
          byte_cnt_nxt = wsdf_pkg::EXT64_FIRST_IDX;
          phase_nxt    = wsdf_pkg::PH_EXT;
        end else begin
          acc_nxt      = {{(LW-7){1'b0}}, stream_byte[6:0]};
          acc_high_nxt = 1'b0;
          hdr_size_nxt = wsdf_pkg::HDR_SIZE_SHORT;
          if (len_reject(acc_nxt, 1'b0, fin_r, opcode_r, max_len_r)) begin
            res_valid       = 1'b1;
            res.result_kind = wsdf_pkg::KIND_ERROR;
            res.error_code  = wsdf_pkg::ERR_LIMIT;
            phase_nxt       = wsdf_pkg::PH_HDR0;
          end else begin
            phase_nxt    = wsdf_pkg::PH_MASK;
            byte_cnt_nxt = 3'd0;
            mask_key_nxt = '0;
          end
        end
      end

      wsdf_pkg::PH_EXT: begin
        if (hdr_size_r == wsdf_pkg::HDR_SIZE_EXT64 &&
            byte_cnt_r == wsdf_pkg::EXT64_FIRST_IDX && stream_byte[7]) begin
          res_valid       = 1'b1;
          res.result_kind = wsdf_pkg::KIND_ERROR;
          res.error_code  = wsdf_pkg::ERR_LEN_TOP;
          phase_nxt       = wsdf_pkg::PH_HDR0;
        end else begin
          acc_nxt      = ext_acc;
          acc_high_nxt = ext_high;
          if (byte_cnt_r == 3'd0) begin
            if (len_reject(ext_acc, ext_high, fin_r, opcode_r, max_len_r)) begin
              res_valid       = 1'b1;
              res.result_kind = wsdf_pkg::KIND_ERROR;
              res.error_code  = wsdf_pkg::ERR_LIMIT;
              phase_nxt       = wsdf_pkg::PH_HDR0;
            end else begin
              phase_nxt    = wsdf_pkg::PH_MASK;
              mask_key_nxt = '0;
            end
          end else begin
            byte_cnt_nxt = byte_cnt_r - 3'd1;
          end
        end
      end

      wsdf_pkg::PH_MASK: begin
        mask_key_nxt = {mask_key_r[23:0], stream_byte};
        if (byte_cnt_r < wsdf_pkg::MASK_LAST_IDX) begin
          byte_cnt_nxt = byte_cnt_r + 3'd1;
        end else begin
          byte_cnt_nxt       = 3'd0;
          res_valid          = 1'b1;
          res.result_kind    = wsdf_pkg::KIND_HEADER;
          res.final_fragment = fin_r;
          res.frame_opcode   = opcode_r;
          res.payload_length = acc_r;
          res.frame_bytes    = {{(LW-3){1'b0}}, hdr_size_r} + (LW+1)'(4) + {1'b0, acc_r};
          remain_nxt         = acc_r;
          mask_pos_nxt       = 2'd0;
          if (acc_r == '0) begin
            res.last_of_frame = 1'b1;
            phase_nxt         = wsdf_pkg::PH_HDR0;
          end else begin
            phase_nxt = wsdf_pkg::PH_DATA;
          end
        end
      end

      wsdf_pkg::PH_DATA: begin
        res_valid          = 1'b1;
        res.result_kind    = wsdf_pkg::KIND_PAYLOAD;
        res.final_fragment = fin_r;
        res.frame_opcode   = opcode_r;
        res.payload_length = acc_r;
        res.frame_bytes    = {{(LW-3){1'b0}}, hdr_size_r} + (LW+1)'(4) + {1'b0, acc_r};
        res.payload_byte   = stream_byte ^ key_byte;
        mask_pos_nxt       = mask_pos_r + 2'd1;
        remain_nxt         = remain_dec;
        if (remain_dec == '0) begin
          res.last_of_frame = 1'b1;
          phase_nxt         = wsdf_pkg::PH_HDR0;
        end
      end

      default: begin
        // first header byte; unused phase codes land here as well
        fin_nxt    = stream_byte[7];
        opcode_nxt = stream_byte[3:0];
        if (stream_byte[6:4] != 3'd0) begin
          res_valid       = 1'b1;
          res.result_kind = wsdf_pkg::KIND_ERROR;
          res.error_code  = wsdf_pkg::ERR_FRAMING;
          phase_nxt       = wsdf_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsdf_pkg::PH_HDR1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsdf_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsdf_pkg::PH_HDR0;
      fin_r      <= 1'b0;
      opcode_r   <= 4'd0;
      acc_r      <= '0;
      acc_high_r <= 1'b0;
      hdr_size_r <= wsdf_pkg::HDR_SIZE_SHORT;
      byte_cnt_r <= 3'd0;
      mask_key_r <= '0;
      remain_r   <= '0;
      mask_pos_r <= 2'd0;
    end else if (byte_take) begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      acc_r      <= acc_nxt;
      acc_high_r <= acc_high_nxt;
      hdr_size_r <= hdr_size_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      mask_key_r <= mask_key_nxt;
      remain_r   <= remain_nxt;
      mask_pos_r <= mask_pos_nxt;
    end
  end

  a_err_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_take && res_valid && res.result_kind == wsdf_pkg::KIND_ERROR)
      |=> phase_r == wsdf_pkg::PH_HDR0)
    else $error("parser did not return to header phase after an error");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == wsdf_pkg::KIND_ERROR)
      |-> (res.payload_length == '0 && res.frame_bytes == '0 &&
           res.payload_byte == 8'd0 && !res.last_of_frame && !res.final_fragment))
    else $error("error item carries frame fields");

  a_empty_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == wsdf_pkg::KIND_HEADER && res.last_of_frame)
      |-> res.payload_length == '0)
    else $error("empty-frame header with nonzero length");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsdf_pkg::PH_DATA) |-> remain_r != '0)
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

### rtl/wsdf_out_skid.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module wsdf_out_skid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wsdf_pkg::result_t  push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output wsdf_pkg::result_t       out_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  wsdf_pkg::result_t main_d_r, main_d_nxt;
  wsdf_pkg::result_t skid_d_r, skid_d_nxt;
  logic              pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      // no push while the skid holds an item
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!main_v_r || pop) begin
      main_v_nxt = push;
      main_d_nxt = push_data;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

### rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket client frame deframer.
//
//   channel   direction  handshake           payload
//   in_*      input      in_valid/in_stall   in_stream_byte
//   out_*     output     out_valid/out_stall result kind, header fields, byte, error
//   cfg_*     input      cfg_wr_en           cfg_wr_data (max_payload_bytes)
//
// One byte per cycle while in_stall is low; results go to the output or skid
// register. Header, extended length and first three mask bytes give only errors.
// in_stall rises only when both output and skid registers hold items. Reset
// (rst_n low, synchronous) puts the parser at the first header byte and the size
// limit at 1 MiB. cfg writes are taken at edges with cfg_wr_en high, not in reset.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [wsdf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_stream_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_result_kind,
  output logic                             out_final_fragment,
  output logic [3:0]                       out_frame_opcode,
  output logic [wsdf_pkg::LEN_W-1:0]       out_payload_length,
  output logic [wsdf_pkg::LEN_W:0]         out_frame_bytes,
  output logic [7:0]                       out_payload_byte,
  output logic                             out_last_of_frame,
  output logic [1:0]                       out_error_code
);

  logic              byte_take;
  logic              res_valid;
  logic              buf_full;
  wsdf_pkg::result_t res;
  wsdf_pkg::result_t out_item;

  assign in_stall  = buf_full;
  assign byte_take = in_valid && !buf_full;

  wsdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_take   (byte_take),
    .stream_byte (in_stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsdf_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_take && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_item)
  );

  assign out_result_kind    = out_item.result_kind;
  assign out_final_fragment = out_item.final_fragment;
  assign out_frame_opcode   = out_item.frame_opcode;
  assign out_payload_length = out_item.payload_length;
  assign out_frame_bytes    = out_item.frame_bytes;
  assign out_payload_byte   = out_item.payload_byte;
  assign out_last_of_frame  = out_item.last_of_frame;
  assign out_error_code     = out_item.error_code;

endmodule

`default_nettype wire

### bench/tb_websocket_frame_deframer_top.sv
// Self-checking bench for the WebSocket frame deframer: random streams vs. a built-in predictor.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;
  import wsdf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int MASK_KEY_BYTES = 4;

  // opcodes; control opcodes start at close
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_stream_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic out_final_fragment;
  logic [3:0] out_frame_opcode;
  logic [LEN_W-1:0] out_payload_length;
  logic [LEN_W:0] out_frame_bytes;
  logic [7:0] out_payload_byte;
  logic out_last_of_frame;
  logic [1:0] out_error_code;

  websocket_frame_deframer_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_stream_byte(in_stream_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_kind(out_result_kind),
    .out_final_fragment(out_final_fragment),
    .out_frame_opcode(out_frame_opcode),
    .out_payload_length(out_payload_length),
    .out_frame_bytes(out_frame_bytes),
    .out_payload_byte(out_payload_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // parser shadow state
  phase_t parse_ph = PH_HDR0;
  logic fin_q = 1'b0;
  logic [3:0] opc_q = 4'h0;
  logic [63:0] len_acc = '0;
  logic [3:0] hdr_size = HDR_SIZE_SHORT;
  logic [2:0] byte_idx = '0;
  logic [31:0] mkey = '0;
  logic [LEN_W-1:0] remaining = '0;
  logic [1:0] mpos = '0;
  logic [LEN_W-1:0] limit_q = MAX_PAYLOAD_RESET;

  logic [7:0] stream_q[$];
  result_t pending_results[$];
  int queued_bytes = 0;
  int bytes_sent = 0;
  int headers_seen = 0;
  int payload_seen = 0;
  int errors_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_done = 0;
  bit idle_on = 1'b1;

  function automatic bit length_rejected(input logic fin, input logic [3:0] opc,
                                         input logic [63:0] len);
    return (opc >= OP_CLOSE && (!fin || len > 64'(CTRL_MAX_LEN))) ||
           len > 64'(limit_q) || (len >> LEN_COUNT_BITS) != 0;
  endfunction

  function automatic result_t error_item(input err_t code);
    result_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    parse_ph = PH_HDR0;
    return r;
  endfunction

  function automatic result_t frame_item(input kind_t k);
    result_t r;
    r = '0;
    r.result_kind = k;
    r.final_fragment = fin_q;
    r.frame_opcode = opc_q;
    r.payload_length = len_acc[LEN_W-1:0];
    r.frame_bytes = (LEN_W+1)'(hdr_size) + (LEN_W+1)'(MASK_KEY_BYTES) +
                    (LEN_W+1)'(len_acc[LEN_W-1:0]);
    return r;
  endfunction

  function automatic bit close_length(output result_t r);
    r = '0;
    if (length_rejected(fin_q, opc_q, len_acc)) begin
      r = error_item(ERR_LIMIT);
      return 1'b1;
    end
    parse_ph = PH_MASK;
    byte_idx = '0;
    mkey = '0;
    return 1'b0;
  endfunction

  // advance the shadow parser by one stream byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    bit has;
    has = 1'b0;
    r = '0;
    case (parse_ph)
      PH_HDR1: begin
        if (!b[7]) begin
          r = error_item(ERR_FRAMING);
          has = 1'b1;
        end else begin
          len_acc = '0;
          if (b[6:0] == LEN7_EXT16) begin
            hdr_size = HDR_SIZE_EXT16;
            byte_idx = EXT16_LAST_IDX;
            parse_ph = PH_EXT;
          end else if (b[6:0] == LEN7_EXT64) begin
            hdr_size = HDR_SIZE_EXT64;
            byte_idx = EXT64_FIRST_IDX;
            parse_ph = PH_EXT;
          end else begin
            hdr_size = HDR_SIZE_SHORT;
            len_acc = 64'(b[6:0]);
            has = close_length(r);
          end
        end
      end
      PH_EXT: begin
        if (hdr_size == HDR_SIZE_EXT64 && byte_idx == EXT64_FIRST_IDX && b[7]) begin
          r = error_item(ERR_LEN_TOP);
          has = 1'b1;
        end else begin
          len_acc = {len_acc[55:0], b};
          if (byte_idx == 3'd0) has = close_length(r);
          else byte_idx = byte_idx - 3'd1;
        end
      end
      PH_MASK: begin
        mkey = {mkey[23:0], b};
        if (byte_idx < MASK_LAST_IDX) begin
          byte_idx = byte_idx + 3'd1;
        end else begin
          byte_idx = '0;
          r = frame_item(KIND_HEADER);
          remaining = len_acc[LEN_W-1:0];
          mpos = '0;
          has = 1'b1;
          if (remaining == '0) begin
            r.last_of_frame = 1'b1;
            parse_ph = PH_HDR0;
          end else begin
            parse_ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        r = frame_item(KIND_PAYLOAD);
        r.payload_byte = b ^ mkey[8*(3-mpos) +: 8];
        mpos = mpos + 2'd1;
        remaining = remaining - 1'b1;
        has = 1'b1;
        if (remaining == '0) begin
          r.last_of_frame = 1'b1;
          parse_ph = PH_HDR0;
        end
      end
      default: begin
        fin_q = b[7];
        opc_q = b[3:0];
        if (b[6:4] != 3'b000) begin
          r = error_item(ERR_FRAMING);
          has = 1'b1;
        end else begin
          parse_ph = PH_HDR1;
        end
      end
    endcase
    return has;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
    queued_bytes++;
  endfunction

  function automatic len_form_t form_for(input logic [63:0] len);
    int pick;
    pick = $urandom_range(0, 9);
    if (len > 64'hFFFF || pick == 0) return LEN_EXT64;
    if (len > 64'(CTRL_MAX_LEN) || pick == 1) return LEN_EXT16;
    return LEN_SHORT;
  endfunction

  // queue one frame; stops at the byte where the parser is expected to reject it
  function automatic void queue_frame(input logic fin, input logic [2:0] rsv,
                                      input logic [3:0] opc, input logic masked,
                                      input logic [63:0] len, input len_form_t form);
    logic [31:0] key;
    logic [6:0] len7;
    int i;
    key = $urandom;
    put_byte({fin, rsv, opc});
    if (rsv != 3'b000) return;
    case (form)
      LEN_SHORT: len7 = len[6:0];
      LEN_EXT16: len7 = LEN7_EXT16;
      default: len7 = LEN7_EXT64;
    endcase
    put_byte({masked, len7});
    if (!masked) return;
    if (form == LEN_EXT16) begin
      put_byte(len[15:8]);
      put_byte(len[7:0]);
    end else if (form == LEN_EXT64) begin
      for (i = 7; i >= 0; i--) begin
        put_byte(len[8*i +: 8]);
        if (i == 7 && len[63]) return;
      end
    end
    if (length_rejected(fin, opc, len)) return;
    for (i = MASK_KEY_BYTES - 1; i >= 0; i--) put_byte(key[8*i +: 8]);
    for (i = 0; i < int'(len); i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // mostly well-formed frames with random content, some broken headers and noise
  function automatic void queue_random(input int n);
    int target, pick, k, i;
    logic [63:0] len;
    logic [3:0] opc;
    logic fin;
    target = queued_bytes + n;
    while (queued_bytes < target) begin
      pick = $urandom_range(0, 99);
      opc = 4'($urandom_range(0, 7));
      fin = $urandom_range(0, 3) != 0;
      len = 64'($urandom_range(0, 20));
      if (pick < 72) begin
        if ($urandom_range(0, 4) == 0) begin
          opc = OP_CLOSE | 4'($urandom_range(0, 7));
          fin = 1'b1;
          len = ($urandom_range(0, 9) == 0) ? 64'(CTRL_MAX_LEN) : 64'($urandom_range(0, 12));
        end else begin
          k = $urandom_range(0, 99);
          if (k < 10) len = 0;
          else if (k < 65) len = 64'($urandom_range(1, 16));
          else if (k < 83) len = 64'($urandom_range(17, 125));
          else if (k < 96) len = 64'($urandom_range(126, 300));
          else len = (limit_q <= 300) ? 64'(limit_q) : 64'($urandom_range(0, 300));
        end
        queue_frame(fin, 3'b000, opc, 1'b1, len, form_for(len));
      end else if (pick < 92) begin
        case ($urandom_range(0, 5))
          0: queue_frame(fin, 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15)), 1'b1,
                         len, LEN_SHORT);
          1: queue_frame(fin, 3'b000, 4'($urandom_range(0, 15)), 1'b0, len, form_for(len));
          2: queue_frame(fin, 3'b000, opc, 1'b1, {1'b1, 31'($urandom), 32'($urandom)},
                         LEN_EXT64);
          3: queue_frame(1'b0, 3'b000, OP_CLOSE | 4'($urandom_range(0, 7)), 1'b1, len,
                         form_for(len));
          4: begin
            len = 64'($urandom_range(126, 400));
            queue_frame(1'b1, 3'b000, OP_CLOSE | 4'($urandom_range(0, 7)), 1'b1, len,
                        form_for(len));
          end
          default: begin
            if (limit_q != '1 && $urandom_range(0, 1) == 0)
              len = 64'(limit_q) + 64'($urandom_range(1, 20));
            else
              len = {1'b0, 31'($urandom), 8'($urandom_range(1, 255)), 24'($urandom)};
            queue_frame(1'b1, 3'b000, opc, 1'b1, len, form_for(len));
          end
        endcase
      end else if (limit_q <= 4096) begin
        // noise only where a stray length cannot swallow much of the stream
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic wait_drained();
    while (stream_q.size() > 0 || in_valid || pending_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_limit(input logic [LEN_W-1:0] v);
    // silent bytes may still be in the parser
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_q = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    result_t res;
    int send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_stream_byte, res))
          pending_results.insert(pending_results.size(), res);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (stream_q.size() > 0) begin
          in_valid <= 1'b1;
          in_stream_byte <= stream_q.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    result_t want;
    int hold_left;
    int stall_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item, kind %0d", out_result_kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_result_kind));
          check_field("final_fragment", 32'(want.final_fragment), 32'(out_final_fragment));
          check_field("frame_opcode", 32'(want.frame_opcode), 32'(out_frame_opcode));
          check_field("payload_length", 32'(want.payload_length), 32'(out_payload_length));
          check_field("frame_bytes", 32'(want.frame_bytes), 32'(out_frame_bytes));
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
          check_field("last_of_frame", 32'(want.last_of_frame), 32'(out_last_of_frame));
          check_field("error_code", 32'(want.error_code), 32'(out_error_code));
          case (want.result_kind)
            KIND_HEADER: headers_seen++;
            KIND_PAYLOAD: payload_seen++;
            default: errors_seen++;
          endcase
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_websocket_frame_deframer_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // header corner cases at the reset size limit
    queue_frame(1'b1, 3'b111, OP_TEXT, 1'b1, 0, LEN_SHORT);
    queue_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 5, LEN_SHORT);
    queue_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 0, LEN_SHORT);
    queue_frame(1'b0, 3'b000, OP_CONT, 1'b1, 3, LEN_SHORT);
    queue_frame(1'b0, 3'b000, OP_PING, 1'b1, 0, LEN_SHORT);
    queue_frame(1'b1, 3'b000, OP_PONG, 1'b1, 126, LEN_EXT16);
    queue_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 64'h8000_0000_0000_0000, LEN_EXT64);
    wait_drained();

    queue_random(500);
    wait_drained();

    set_limit('0);
    queue_random(200);
    wait_drained();

    // receiver holds off while a long payload streams in
    set_limit('1);
    queue_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 60, LEN_SHORT);
    hold_requests++;
    queue_random(300);
    wait_drained();

    set_limit(LEN_W'($urandom_range(1, 300)));
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    set_limit(CTRL_MAX_LEN);
    queue_random(200);
    wait_drained();

    set_limit(MAX_PAYLOAD_RESET);
    idle_on = 1'b0;
    queue_random(100);
    queue_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 64'd130, LEN_EXT16);
    wait_drained();
    repeat (8) @(posedge clk);

    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d stream bytes; checked %0d headers, %0d payload bytes, %0d errors.",
             bytes_sent, headers_seen, payload_seen, errors_seen);
    $display("Size limit swept through reset, zero, max, random, 125 and back to reset.");
    if (mismatches == 0)
      $display("tb_websocket_frame_deframer_top: done, clean");
    else
      $display("tb_websocket_frame_deframer_top: done, errors");
    $finish;
  end

endmodule
